// ===== rtl/core/tksd_pkg.sv =====
// ----------------------------------------------------------------------------
// tksd_pkg: terminal key sequence decoder definitions
// Beat types, phase and key codes, byte constants and small decode helpers.
// ----------------------------------------------------------------------------
package tksd_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_RESIZE  = 2'd2;

  // Byte constants
  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_LBRK   = 8'h5b;  // '['
  localparam logic [7:0] BYTE_TILDE  = 8'h7e;  // '~'
  localparam logic [7:0] BYTE_DEL    = 8'h7f;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] BYTE_NINE   = 8'h39;  // '9'

  // Number of raw bytes carried in one result beat
  localparam int unsigned OUT_BYTES = 4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC1 = 3'd1,
    PH_ESC2 = 3'd2,
    PH_ESC3 = 3'd3,
    PH_UTF8 = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    K_NULL  = 4'd0,
    K_CHAR  = 4'd1,
    K_ESC   = 4'd2,
    K_BS    = 4'd3,
    K_UP    = 4'd4,
    K_DOWN  = 4'd5,
    K_RIGHT = 4'd6,
    K_LEFT  = 4'd7,
    K_HOME  = 4'd8,
    K_END   = 4'd9,
    K_DEL   = 4'd10,
    K_PGUP  = 4'd11,
    K_PGDN  = 4'd12
  } key_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  key_kind;
    logic [7:0]  char_code;
    logic [31:0] raw_bytes;
    logic [2:0]  raw_count;
  } out_t;

  // Total sequence length coded in a UTF-8 lead byte; invalid leads count as one
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    priority if ((c & 8'h80) == 8'h00) len = 3'd1;
    else if ((c & 8'he0) == 8'hc0)     len = 3'd2;
    else if ((c & 8'hf0) == 8'he0)     len = 3'd3;
    else if ((c & 8'hf8) == 8'hf0)     len = 3'd4;
    else                               len = 3'd1;
    return len;
  endfunction

  // Final byte of ESC [ x
  function automatic key_e letter_key(input logic [7:0] b);
    key_e k;
    case (b)
      8'h41:   k = K_UP;     // 'A'
      8'h42:   k = K_DOWN;   // 'B'
      8'h43:   k = K_RIGHT;  // 'C'
      8'h44:   k = K_LEFT;   // 'D'
      8'h48:   k = K_HOME;   // 'H'
      8'h46:   k = K_END;    // 'F'
      default: k = K_ESC;
    endcase
    return k;
  endfunction

  // Digit of ESC [ digit ~
  function automatic key_e tilde_key(input logic [7:0] d);
    key_e k;
    case (d)
      8'h31:   k = K_HOME;  // '1'
      8'h33:   k = K_DEL;   // '3'
      8'h34:   k = K_END;   // '4'
      8'h35:   k = K_PGUP;  // '5'
      8'h36:   k = K_PGDN;  // '6'
      8'h37:   k = K_HOME;  // '7'
      8'h38:   k = K_END;   // '8'
      default: k = K_ESC;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/terminal_key_sequence_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_unit: terminal key sequence decoder
// Turns terminal events (bytes, timeouts, resizes) into decoded keypresses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one event per
//   beat: a received byte, a read timeout or a window resize. Output channel
//   (out_valid_o / out_stall_i / out_data_o) carries one decoded key per beat
//   with its raw bytes (first byte in bits 7..0) and their count.
//   An event produces zero or one key: ESC sequences and UTF-8 characters
//   span several events and give their key on the event that completes them.
//   An accepted event is held in the event register and decoded into the
//   result register, whose beat is on out_data_o. Throughput: one event per
//   cycle while the output is not stalled; a single pass of logic between
//   the two registers decodes the event and updates the decoder state.
//   When the receiver stalls, the result register holds its beat; the event
//   register still takes one more event, and in_stall_o rises only while
//   both registers are full and the output is stalled.
//   Reset (rst_ni low, asynchronous) empties both registers and returns the
//   decoder to idle with no bytes held.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder_unit #(
  parameter int unsigned MAX_RAW_BYTES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tksd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tksd_pkg::out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_RAW_BYTES);
  localparam int unsigned CNT_W = $clog2(MAX_RAW_BYTES + 1);

  // Event register
  logic          in_valid_q;
  tksd_pkg::in_t in_data_q;

  // Decoder state
  tksd_pkg::phase_e phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]       need_q, need_d;
  logic [7:0]       store_q [MAX_RAW_BYTES];
  logic [7:0]       store_d [MAX_RAW_BYTES];

  // Result register
  logic           out_valid_q;
  tksd_pkg::out_t out_data_q, out_data_d;

  logic             adv;
  logic             emit;
  tksd_pkg::key_e   kind;
  logic             is_byte;
  logic             is_resize;
  logic [7:0]       c;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] n_out;

  // Handshake: decode when the event register is full and the result slot frees
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Byte capture into the raw store
  assign is_byte   = (in_data_q.mode == tksd_pkg::MODE_BYTE);
  assign is_resize = (in_data_q.mode == tksd_pkg::MODE_RESIZE);
  assign c         = in_data_q.data_byte;
  assign cnt_base  = (phase_q == tksd_pkg::PH_IDLE) ? '0 : cnt_q;

  always_comb begin
    store_d = store_q;
    cnt_new = cnt_base;
    if (is_byte && (cnt_base < CNT_W'(MAX_RAW_BYTES))) begin
      store_d[cnt_base[IDX_W-1:0]] = c;
      cnt_new = cnt_base + CNT_W'(1);
    end
  end

  // Sequence decode: next phase and key
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_new;
    need_d  = need_q;
    emit    = 1'b0;
    kind    = tksd_pkg::K_NULL;
    unique case (phase_q)
      tksd_pkg::PH_IDLE: begin
        if (!is_byte) begin
          emit = is_resize;
          kind = tksd_pkg::K_NULL;
        end else if (c == tksd_pkg::BYTE_ESC) begin
          phase_d = tksd_pkg::PH_ESC1;
        end else if (tksd_pkg::lead_len(c) == 3'd1) begin
          emit = 1'b1;
          kind = (c == tksd_pkg::BYTE_DEL || c == tksd_pkg::BYTE_BS) ?
                 tksd_pkg::K_BS : tksd_pkg::K_CHAR;
        end else begin
          phase_d = tksd_pkg::PH_UTF8;
          need_d  = tksd_pkg::lead_len(c);
        end
      end
      tksd_pkg::PH_ESC1: begin
        if (!is_byte) begin
          emit = 1'b1;
          kind = tksd_pkg::K_ESC;
        end else begin
          phase_d = tksd_pkg::PH_ESC2;
        end
      end
      tksd_pkg::PH_ESC2: begin
        if (!is_byte || store_d[1] != tksd_pkg::BYTE_LBRK) begin
          emit = 1'b1;
          kind = tksd_pkg::K_ESC;
        end else if (c >= tksd_pkg::BYTE_ZERO && c <= tksd_pkg::BYTE_NINE) begin
          phase_d = tksd_pkg::PH_ESC3;
        end else begin
          emit = 1'b1;
          kind = tksd_pkg::letter_key(c);
        end
      end
      tksd_pkg::PH_ESC3: begin
        emit = 1'b1;
        kind = (is_byte && c == tksd_pkg::BYTE_TILDE) ?
               tksd_pkg::tilde_key(store_d[2]) : tksd_pkg::K_ESC;
      end
      tksd_pkg::PH_UTF8: begin
        // Timeout or resize ends the character early
        if (!is_byte || cnt_new >= CNT_W'(need_q) ||
            cnt_new >= CNT_W'(MAX_RAW_BYTES)) begin
          emit = 1'b1;
          kind = tksd_pkg::K_CHAR;
        end
      end
      default: begin
        phase_d = tksd_pkg::PH_IDLE;
        cnt_d   = '0;
        need_d  = '0;
      end
    endcase
    if (emit) begin
      phase_d = tksd_pkg::PH_IDLE;
      cnt_d   = '0;
      need_d  = '0;
    end
  end

  // Result packing: at most four bytes, unused bytes zero
  assign n_out = (cnt_new > CNT_W'(tksd_pkg::OUT_BYTES)) ?
                 CNT_W'(tksd_pkg::OUT_BYTES) : cnt_new;

  always_comb begin
    out_data_d.key_kind  = kind;
    out_data_d.char_code = (n_out != '0) ? store_d[0] : 8'h00;
    out_data_d.raw_count = 3'(n_out);
    out_data_d.raw_bytes = '0;
    for (int i = 0; i < tksd_pkg::OUT_BYTES; i++) begin
      if (CNT_W'(i) < n_out) begin
        out_data_d.raw_bytes[8*i +: 8] = store_d[IDX_W'(i)];
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tksd_pkg::PH_IDLE;
      cnt_q   <= '0;
      need_q  <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      need_q  <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      store_q <= store_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Idle and escape phases hold exactly the bytes seen so far
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tksd_pkg::PH_IDLE |-> cnt_q == '0)
    else $error("idle phase with bytes held");

  a_esc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != tksd_pkg::PH_ESC1 || cnt_q == CNT_W'(1)) &&
    (phase_q != tksd_pkg::PH_ESC2 || cnt_q == CNT_W'(2)) &&
    (phase_q != tksd_pkg::PH_ESC3 || cnt_q == CNT_W'(3)))
    else $error("escape phase and byte count disagree");

  // Gathering UTF-8 means a multi-byte lead with bytes still missing
  a_utf8_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tksd_pkg::PH_UTF8 |->
      (need_q >= 3'd2) && (need_q <= 3'd4) &&
      (cnt_q >= CNT_W'(1)) && (cnt_q < CNT_W'(need_q)))
    else $error("UTF-8 gather state inconsistent");

  // Input stalls only while both registers are full and the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without a full pipeline");

  // A delivered beat never claims more than four bytes, and none means no lead
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.raw_count <= 3'd4) &&
      (out_data_o.raw_count != 3'd0 || out_data_o.char_code == 8'h00))
    else $error("result byte count out of range");
`endif

endmodule
